FILE: sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge, held off while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: sv/bpdc_pkg.sv
package bpdc_pkg;

    // Press-tracking phases
    typedef enum logic [1:0] {
        PH_WAIT_PUSH      = 2'd0,
        PH_WAIT_RELEASE   = 2'd1,
        PH_CHECK_DEBOUNCE = 2'd2,
        PH_WAIT_LONG      = 2'd3
    } phase_t;

    typedef logic [3:0] action_t;
    typedef logic [2:0] colour_t;

    // Action codes
    localparam action_t ACT_NONE       = 4'd0;
    localparam action_t ACT_BAD        = 4'd1;
    localparam action_t ACT_QUICK      = 4'd2;
    localparam action_t ACT_HELD_BASE  = 4'd2;   // held n seconds -> base + n
    localparam action_t ACT_TIMEOUT    = 4'd9;

    localparam colour_t COLOUR_OFF     = 3'd0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_DEBOUNCE   = 1'b0;
    localparam cfg_idx_t REG_LONG_PRESS = 1'b1;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

    localparam int MS_PER_S    = 1000;
    localparam int TIMEOUT_S   = 7;
    localparam int NOW_W       = 32;

    // now mod 100 by folding: 8-bit chunk weights 256^i mod 100
    localparam int MAX_CHUNKS = 8;
    localparam logic [6:0] MOD100_W8 [MAX_CHUNKS] =
        '{7'd1, 7'd56, 7'd36, 7'd16, 7'd96, 7'd76, 7'd56, 7'd36};
    localparam int FOLD_W   = 18;      // up to 8 * 255 * 99
    localparam int RES_W    = 13;      // second fold result, below 7150
    localparam int W10_MOD  = 24;      // 2^10 mod 100
    // floor(x / 50) = (x * RECIP50) >> RECIP_SH for x below 7150
    localparam int RECIP_W  = 15;
    localparam logic [RECIP_W-1:0] RECIP50 = 15'd20972;
    localparam int RECIP_SH = 20;

endpackage

FILE: sv/bpdc_channels.sv
// Sample channel: one button sample per word
interface bpdc_sample_if;
    logic        valid;
    logic        ready;
    logic        pressed;
    logic [31:0] now_ms;

    modport source (output valid, output pressed, output now_ms, input ready);
    modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

// Result channel: one classification word per sample
interface bpdc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] fsm_state;
    logic [3:0] action;
    logic       long_active;
    logic [2:0] colour_code;
    logic       blink_on;

    modport source (output valid, output fsm_state, output action, output long_active,
                    output colour_code, output blink_on, input ready);
    modport sink   (input valid, input fsm_state, input action, input long_active,
                    input colour_code, input blink_on, output ready);
endinterface

FILE: sv/button_press_duration_classifier_unit.sv
// Channel   Dir  Handshake     Word
// sample    in   valid/ready   pressed, now_ms
// result    out  valid/ready   fsm_state, action, long_active, colour_code, blink_on
// cfg       in   cfg_we        cfg_index, cfg_wdata
//
// Two register stages, sample then result register; one word per cycle unless result stalls.
// Result valid rises when an accepted word leaves the sample register for the result register.
// The phase machine updates as a word moves from the sample stage to the result stage.
// A stalled result stalls both stages; ready drops only when the result register is full
// and not being taken.
// Reset clears the phase, press start, action, long flag and both valid bits.
`include "assert_macros.svh"

module button_press_duration_classifier_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  bpdc_pkg::cfg_idx_t         cfg_index,
    input  logic [bpdc_pkg::CFG_W-1:0] cfg_wdata,
    bpdc_sample_if.sink                sample,
    bpdc_result_if.source              result
);
    import bpdc_pkg::*;

    localparam int NCH   = (TIME_BITS + 7) / 8;
    localparam int PAD_W = NCH * 8;
    localparam int PROD_W = RES_W + RECIP_W;

    // Config registers
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Pipeline control
    logic a_valid_reg;
    logic b_valid_reg;
    logic adv;
    logic step;

    assign adv          = !b_valid_reg || result.ready;
    assign step         = adv && a_valid_reg;
    assign sample.ready = adv;
    assign result.valid = b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= sample.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // First fold of now mod 100: weighted sum of 8-bit chunks
    logic [TIME_BITS-1:0] now_in;
    logic [PAD_W-1:0]     now_pad;
    logic [FOLD_W-1:0]    fold_next;

    assign now_in  = TIME_BITS'(sample.now_ms);
    assign now_pad = PAD_W'(now_in);

    always_comb
    begin
        fold_next = '0;
        for (int i = 0; i < NCH; i++)
        begin
            fold_next = fold_next + FOLD_W'(now_pad[i*8 +: 8]) * FOLD_W'(MOD100_W8[i]);
        end
    end

    // Sample stage registers
    logic                 a_pressed_reg;
    logic [TIME_BITS-1:0] a_now_reg;
    logic [FOLD_W-1:0]    a_fold_reg;

    always_ff @(posedge clk)
    begin
        if (adv && sample.valid)
        begin
            a_pressed_reg <= sample.pressed;
            a_now_reg     <= now_in;
            a_fold_reg    <= fold_next;
        end
    end

    // Blink phase: second fold, then parity of floor(x / 50)
    logic [RES_W-1:0]  res_mod;
    logic [PROD_W-1:0] res_prod;
    logic              blink_raw;

    assign res_mod   = RES_W'(a_fold_reg[9:0])
                     + RES_W'(a_fold_reg[FOLD_W-1:10]) * RES_W'(W10_MOD);
    assign res_prod  = PROD_W'(res_mod) * PROD_W'(RECIP50);
    assign blink_raw = ~res_prod[RECIP_SH];

    // Hold time and its whole-second grade
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [TIME_BITS-1:0] press_start_reg;
    logic [TIME_BITS-1:0] press_start_next;
    action_t              action_reg;
    action_t              action_next;
    logic                 long_flag_reg;
    logic                 long_flag_next;
    colour_t              colour_next;
    logic                 blink_next;

    logic [TIME_BITS-1:0] elapsed;
    logic [2:0]           secs;
    logic                 over_long;
    logic                 over_debounce;

    assign elapsed       = a_now_reg - press_start_reg;
    assign over_long     = elapsed > TIME_BITS'(long_press_reg);
    assign over_debounce = elapsed > TIME_BITS'(debounce_reg);

    always_comb
    begin
        secs = 3'd0;
        for (int k = 1; k <= TIMEOUT_S; k++)
        begin
            if (elapsed >= TIME_BITS'(k * MS_PER_S))
            begin
                secs = 3'(k);
            end
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_WAIT_PUSH:
            begin
                if (a_pressed_reg)
                    phase_next = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE:
            begin
                if (!a_pressed_reg)
                    phase_next = PH_CHECK_DEBOUNCE;
                else if (over_long)
                    phase_next = PH_WAIT_LONG;
            end
            PH_CHECK_DEBOUNCE:
            begin
                phase_next = PH_WAIT_PUSH;
            end
            PH_WAIT_LONG:
            begin
                if (!a_pressed_reg)
                    phase_next = PH_WAIT_PUSH;
            end
            default:
            begin
                phase_next = PH_WAIT_PUSH;
            end
        endcase
    end

    // Press start, action, long flag, colour and blink
    always_comb
    begin
        press_start_next = press_start_reg;
        action_next      = action_reg;
        long_flag_next   = long_flag_reg;
        colour_next      = COLOUR_OFF;
        blink_next       = 1'b0;
        case (phase_reg)
            PH_WAIT_PUSH:
            begin
                if (a_pressed_reg)
                    press_start_next = a_now_reg;
            end
            PH_WAIT_RELEASE:
            begin
                if (a_pressed_reg && over_long)
                    long_flag_next = 1'b1;
            end
            PH_CHECK_DEBOUNCE:
            begin
                action_next = over_debounce ? ACT_QUICK : ACT_BAD;
            end
            PH_WAIT_LONG:
            begin
                if (!a_pressed_reg)
                begin
                    long_flag_next = 1'b0;
                end
                else
                begin
                    long_flag_next = 1'b1;
                    blink_next     = blink_raw;
                    if (secs == 3'(TIMEOUT_S))
                    begin
                        action_next = ACT_TIMEOUT;
                    end
                    else if (secs != 3'd0)
                    begin
                        action_next = ACT_HELD_BASE + action_t'(secs);
                        colour_next = secs;
                    end
                end
            end
            default:
            begin
                action_next = action_reg;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT_PUSH;
            press_start_reg <= '0;
            action_reg      <= ACT_NONE;
            long_flag_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            press_start_reg <= press_start_next;
            action_reg      <= action_next;
            long_flag_reg   <= long_flag_next;
        end
    end

    // Result register
    logic [1:0] out_state_reg;
    action_t    out_action_reg;
    logic       out_long_reg;
    colour_t    out_colour_reg;
    logic       out_blink_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_state_reg  <= phase_next;
            out_action_reg <= action_next;
            out_long_reg   <= long_flag_next;
            out_colour_reg <= colour_next;
            out_blink_reg  <= blink_next;
        end
    end

    assign result.fsm_state   = out_state_reg;
    assign result.action      = out_action_reg;
    assign result.long_active = out_long_reg;
    assign result.colour_code = out_colour_reg;
    assign result.blink_on    = out_blink_reg;

    // Checks
    `ASSERT_ALWAYS(a_long_flag_phase, clk,
        long_flag_reg == (phase_reg == PH_WAIT_LONG),
        "long flag out of step with phase")
    `ASSERT_RST(a_colour_only_long, clk, rst_n,
        (b_valid_reg && out_colour_reg != COLOUR_OFF) |-> (out_state_reg == PH_WAIT_LONG),
        "colour shown outside long release")
    `ASSERT_RST(a_debounce_one_word, clk, rst_n,
        (step && phase_reg == PH_CHECK_DEBOUNCE) |=> (phase_reg == PH_WAIT_PUSH),
        "debounce check did not return to wait push")
    `ASSERT_RST(a_stall_holds_state, clk, rst_n,
        (b_valid_reg && !result.ready) |=> ($stable(phase_reg) && $stable(action_reg)),
        "state moved while result stalled")

endmodule
